>>> rtl/stc_pkg.sv
// Shared types, codes and helper functions for the SMPTE timecode counter.
package stc_pkg;

    // Field widths of the timecode
    localparam int HOURS_W   = 5;
    localparam int MINUTES_W = 6;
    localparam int SECONDS_W = 6;
    localparam int FRAMES_W  = 5;
    localparam int OP_W      = 3;
    localparam int MODE_W    = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INC  = 3'd0;
    localparam logic [OP_W-1:0] OP_DEC  = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD = 3'd4;

    // Frame mode codes
    localparam logic [MODE_W-1:0] MODE_30   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_25   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_24   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NTSC = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PALM = 3'd4;

    // Register index of the frame mode
    localparam logic REG_FRAME_MODE = 1'b0;

    // Range limits
    localparam logic [HOURS_W-1:0]   MAX_HOURS   = 5'd23;
    localparam logic [MINUTES_W-1:0] MAX_MINUTES = 6'd59;
    localparam logic [SECONDS_W-1:0] MAX_SECONDS = 6'd59;
    localparam logic [FRAMES_W-1:0]  RATE_30     = 5'd30;
    localparam logic [FRAMES_W-1:0]  RATE_25     = 5'd25;
    localparam logic [FRAMES_W-1:0]  RATE_24     = 5'd24;
    localparam logic [FRAMES_W-1:0]  NTSC_SKIP   = 5'd2;
    localparam logic [FRAMES_W-1:0]  PALM_SKIP   = 5'd4;

    // One timecode value
    typedef struct packed {
        logic [HOURS_W-1:0]   hours;
        logic [MINUTES_W-1:0] minutes;
        logic [SECONDS_W-1:0] seconds;
        logic [FRAMES_W-1:0]  frames;
    } tc_t;

    // Unknown modes behave as 30 fps nondrop.
    function automatic logic [MODE_W-1:0] eff_mode(input logic [MODE_W-1:0] m);
        eff_mode = (m > MODE_PALM) ? MODE_30 : m;
    endfunction

    function automatic logic [FRAMES_W-1:0] frame_rate(input logic [MODE_W-1:0] m);
        case (m)
            MODE_25: frame_rate = RATE_25;
            MODE_24: frame_rate = RATE_24;
            default: frame_rate = RATE_30;
        endcase
    endfunction

endpackage

>>> rtl/stc_step.sv
// Combinational next-timecode logic for one item of the timecode counter.
module stc_step
    import stc_pkg::*;
(
    input  tc_t                  cur,
    input  logic [MODE_W-1:0]    frame_mode,
    input  logic [OP_W-1:0]      operation,
    input  logic [HOURS_W-1:0]   operand_hours,
    input  logic [MINUTES_W-1:0] operand_minutes,
    input  logic [SECONDS_W-1:0] operand_seconds,
    input  logic [FRAMES_W-1:0]  operand_frames,
    output tc_t                  nxt,
    output logic                 matches_operand,
    output logic                 refused
);

    // True when the minute count is a multiple of ten.
    function automatic logic min_mod10_zero(input logic [MINUTES_W-1:0] m);
        min_mod10_zero = (m == 6'd0) || (m == 6'd10) || (m == 6'd20) ||
                         (m == 6'd30) || (m == 6'd40) || (m == 6'd50);
    endfunction

    // True when the minute count is a multiple of twenty.
    function automatic logic min_mod20_zero(input logic [MINUTES_W-1:0] m);
        min_mod20_zero = (m == 6'd0) || (m == 6'd20) || (m == 6'd40);
    endfunction

    // One frame forward with carries.
    function automatic tc_t step_forward(input tc_t t, input logic [FRAMES_W-1:0] rate);
        tc_t r;
        r = t;
        if ((t.frames + 5'd1) < rate) begin
            r.frames = t.frames + 5'd1;
        end
        else begin
            r.frames = '0;
            if (t.seconds < MAX_SECONDS) begin
                r.seconds = t.seconds + 6'd1;
            end
            else begin
                r.seconds = '0;
                if (t.minutes < MAX_MINUTES) begin
                    r.minutes = t.minutes + 6'd1;
                end
                else begin
                    r.minutes = '0;
                    r.hours   = (t.hours < MAX_HOURS) ? t.hours + 5'd1 : '0;
                end
            end
        end
        step_forward = r;
    endfunction

    // One frame back with borrows.
    function automatic tc_t step_back(input tc_t t, input logic [FRAMES_W-1:0] rate);
        tc_t r;
        r = t;
        if (t.frames != '0) begin
            r.frames = t.frames - 5'd1;
        end
        else begin
            r.frames = rate - 5'd1;
            if (t.seconds != '0) begin
                r.seconds = t.seconds - 6'd1;
            end
            else begin
                r.seconds = MAX_SECONDS;
                if (t.minutes != '0) begin
                    r.minutes = t.minutes - 6'd1;
                end
                else begin
                    r.minutes = MAX_MINUTES;
                    r.hours   = (t.hours != '0) ? t.hours - 5'd1 : MAX_HOURS;
                end
            end
        end
        step_back = r;
    endfunction

    logic [MODE_W-1:0]    mode;
    logic [FRAMES_W-1:0]  rate;
    logic [FRAMES_W-1:0]  rate_m1;
    logic                 drop;
    tc_t                  opnd;
    tc_t                  base;
    tc_t                  fwd;
    tc_t                  back;
    logic                 ntsc_back;
    logic                 palm_back;

    // Add and subtract chain
    logic [FRAMES_W:0]    f_sum;
    logic [SECONDS_W:0]   s_sum;
    logic [MINUTES_W:0]   m_sum;
    logic [HOURS_W:0]     h_sum;
    logic                 f_cy;
    logic                 s_cy;
    logic                 m_cy;
    logic [SECONDS_W:0]   s_need;
    logic [MINUTES_W:0]   m_need;
    logic [HOURS_W:0]     h_need;
    logic                 f_bw;
    logic                 s_bw;
    logic                 m_bw;
    tc_t                  sum_tc;
    tc_t                  dif_tc;

    // Mode decode, operand clamping and stored-frame clamping
    always_comb
    begin
        mode    = eff_mode(frame_mode);
        rate    = frame_rate(mode);
        rate_m1 = rate - 5'd1;
        drop    = (mode == MODE_NTSC) || (mode == MODE_PALM);
        opnd.hours   = (operand_hours > MAX_HOURS) ? MAX_HOURS : operand_hours;
        opnd.minutes = (operand_minutes > MAX_MINUTES) ? MAX_MINUTES : operand_minutes;
        opnd.seconds = (operand_seconds > MAX_SECONDS) ? MAX_SECONDS : operand_seconds;
        opnd.frames  = (operand_frames > rate_m1) ? rate_m1 : operand_frames;
        base         = cur;
        base.frames  = (cur.frames > rate_m1) ? rate_m1 : cur.frames;
    end

    // Increment with the drop-frame skip at the start of a minute
    always_comb
    begin
        fwd = step_forward(base, rate);
        if ((fwd.frames == '0) && (fwd.seconds == '0)) begin
            if ((mode == MODE_NTSC) && !min_mod10_zero(fwd.minutes)) begin
                fwd.frames = NTSC_SKIP;
            end
            else if ((mode == MODE_PALM) && !fwd.minutes[0] &&
                     !min_mod20_zero(fwd.minutes)) begin
                fwd.frames = PALM_SKIP;
            end
        end
    end

    // Decrement; landing on the last skipped frame of a minute start jumps past the skipped ones.
    // The minute is nonzero there, so the second step only moves back one minute.
    always_comb
    begin
        back = step_back(base, rate);
        ntsc_back = (back.seconds == '0) && (mode == MODE_NTSC) &&
                    (back.frames == 5'd1) && !min_mod10_zero(back.minutes);
        palm_back = (back.seconds == '0) && (mode == MODE_PALM) &&
                    (back.frames == 5'd3) && !back.minutes[0] &&
                    !min_mod20_zero(back.minutes);
        if (ntsc_back || palm_back) begin
            back.frames  = rate_m1;
            back.seconds = MAX_SECONDS;
            back.minutes = back.minutes - 6'd1;
        end
    end

    // Field-wise add with carry
    always_comb
    begin
        f_sum = {1'b0, base.frames} + {1'b0, opnd.frames};
        f_cy  = (f_sum >= {1'b0, rate});
        sum_tc.frames = f_cy ? FRAMES_W'(f_sum - {1'b0, rate}) : f_sum[FRAMES_W-1:0];
        s_sum = {1'b0, base.seconds} + {1'b0, opnd.seconds} + {{SECONDS_W{1'b0}}, f_cy};
        s_cy  = (s_sum >= 7'd60);
        sum_tc.seconds = s_cy ? SECONDS_W'(s_sum - 7'd60) : s_sum[SECONDS_W-1:0];
        m_sum = {1'b0, base.minutes} + {1'b0, opnd.minutes} + {{MINUTES_W{1'b0}}, s_cy};
        m_cy  = (m_sum >= 7'd60);
        sum_tc.minutes = m_cy ? MINUTES_W'(m_sum - 7'd60) : m_sum[MINUTES_W-1:0];
        h_sum = {1'b0, base.hours} + {1'b0, opnd.hours} + {{HOURS_W{1'b0}}, m_cy};
        sum_tc.hours = (h_sum >= 6'd24) ? HOURS_W'(h_sum - 6'd24) : h_sum[HOURS_W-1:0];
    end

    // Field-wise subtract with borrow
    always_comb
    begin
        f_bw = (base.frames < opnd.frames);
        dif_tc.frames = f_bw ? (base.frames + rate - opnd.frames)
                             : (base.frames - opnd.frames);
        s_need = {1'b0, opnd.seconds} + {{SECONDS_W{1'b0}}, f_bw};
        s_bw   = ({1'b0, base.seconds} < s_need);
        dif_tc.seconds = s_bw ? SECONDS_W'({1'b0, base.seconds} + 7'd60 - s_need)
                              : SECONDS_W'({1'b0, base.seconds} - s_need);
        m_need = {1'b0, opnd.minutes} + {{MINUTES_W{1'b0}}, s_bw};
        m_bw   = ({1'b0, base.minutes} < m_need);
        dif_tc.minutes = m_bw ? MINUTES_W'({1'b0, base.minutes} + 7'd60 - m_need)
                              : MINUTES_W'({1'b0, base.minutes} - m_need);
        h_need = {1'b0, opnd.hours} + {{HOURS_W{1'b0}}, m_bw};
        dif_tc.hours = ({1'b0, base.hours} < h_need)
                       ? HOURS_W'({1'b0, base.hours} + 6'd24 - h_need)
                       : HOURS_W'({1'b0, base.hours} - h_need);
    end

    // Operation select and result flags
    always_comb
    begin
        nxt     = base;
        refused = 1'b0;
        case (operation)
            OP_INC:  nxt = fwd;
            OP_DEC:  nxt = back;
            OP_ADD:
            begin
                if (drop) begin
                    refused = 1'b1;
                end
                else begin
                    nxt = sum_tc;
                end
            end
            OP_SUB:
            begin
                if (drop) begin
                    refused = 1'b1;
                end
                else begin
                    nxt = dif_tc;
                end
            end
            OP_LOAD: nxt = opnd;
            default: nxt = base;
        endcase
        matches_operand = (nxt == opnd);
    end

endmodule

>>> rtl/smpte_timecode_counter_unit.sv
// Top level of the SMPTE timecode counter: channels, item register, state and results.
//
// Usage: each input item carries an operation (increment, decrement, add, subtract
// or load) and an operand timecode. The block applies it to its stored
// hours:minutes:seconds:frames count and returns exactly one result item with the
// new timecode, a flag that it equals the clamped operand, and a refused flag for
// add or subtract in a drop-frame mode.
// Both channels use valid and stall; an item moves on an edge with valid high and
// stall low. An accepted item waits in the item register, where the step logic
// works on it, and moves into the result register once that register is free.
// One item per cycle is sustained while the receiver does not stall, since the
// stored timecode is updated at the same edge that loads the result register.
// When the receiver stalls, the result register holds; one more item may wait in
// the item register, and then in_stall rises until the result is taken.
// Reset empties both registers, sets the timecode to 00:00:00:00 and the frame
// mode to 30 fps nondrop. The frame mode is written through the APB port at
// address 0 and reads back there.
module smpte_timecode_counter_unit
    import stc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      operation,
    input  logic [HOURS_W-1:0]   operand_hours,
    input  logic [MINUTES_W-1:0] operand_minutes,
    input  logic [SECONDS_W-1:0] operand_seconds,
    input  logic [FRAMES_W-1:0]  operand_frames,
    // Output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [HOURS_W-1:0]   result_hours,
    output logic [MINUTES_W-1:0] result_minutes,
    output logic [SECONDS_W-1:0] result_seconds,
    output logic [FRAMES_W-1:0]  result_frames,
    output logic                 matches_operand,
    output logic                 refused
);

    logic [MODE_W-1:0]    frame_mode_reg;
    tc_t                  count_reg;

    logic                 item_valid_reg;
    logic [OP_W-1:0]      op_reg;
    logic [HOURS_W-1:0]   oh_reg;
    logic [MINUTES_W-1:0] om_reg;
    logic [SECONDS_W-1:0] os_reg;
    logic [FRAMES_W-1:0]  of_reg;

    logic                 res_valid_reg;
    tc_t                  res_tc_reg;
    logic                 res_match_reg;
    logic                 res_refused_reg;

    tc_t                  count_next;
    logic                 match_next;
    logic                 refused_next;
    logic                 advance;
    logic                 take;
    logic                 cfg_write;

    // Handshake: the item register advances when the result register is free
    assign advance  = item_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_FRAME_MODE);
    assign prdata    = (paddr[2] == REG_FRAME_MODE) ? {29'd0, frame_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_mode_reg <= MODE_30;
        end
        else if (cfg_write) begin
            frame_mode_reg <= pwdata[MODE_W-1:0];
        end
    end

    // Step logic on the registered item
    stc_step u_step (
        .cur             (count_reg),
        .frame_mode      (frame_mode_reg),
        .operation       (op_reg),
        .operand_hours   (oh_reg),
        .operand_minutes (om_reg),
        .operand_seconds (os_reg),
        .operand_frames  (of_reg),
        .nxt             (count_next),
        .matches_operand (match_next),
        .refused         (refused_next)
    );

    // Item register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
        end
        else if (take) begin
            item_valid_reg <= 1'b1;
        end
        else if (advance) begin
            item_valid_reg <= 1'b0;
        end
    end

    // Item register payload
    always_ff @(posedge clk)
    begin
        if (take) begin
            op_reg <= operation;
            oh_reg <= operand_hours;
            om_reg <= operand_minutes;
            os_reg <= operand_seconds;
            of_reg <= operand_frames;
        end
    end

    // Stored timecode and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else begin
            if (advance) begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (!out_stall) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance) begin
            res_tc_reg      <= count_next;
            res_match_reg   <= match_next;
            res_refused_reg <= refused_next;
        end
    end

    assign out_valid       = res_valid_reg;
    assign result_hours    = res_tc_reg.hours;
    assign result_minutes  = res_tc_reg.minutes;
    assign result_seconds  = res_tc_reg.seconds;
    assign result_frames   = res_tc_reg.frames;
    assign matches_operand = res_match_reg;
    assign refused         = res_refused_reg;

endmodule

>>> bench/stc_checker.sv
// Checker for the timecode counter: watches both channels and the APB port, predicts and compares.
`timescale 1ns / 1ps

module stc_checker
    import stc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    // Input channel
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [OP_W-1:0]      operation,
    input  logic [HOURS_W-1:0]   operand_hours,
    input  logic [MINUTES_W-1:0] operand_minutes,
    input  logic [SECONDS_W-1:0] operand_seconds,
    input  logic [FRAMES_W-1:0]  operand_frames,
    // Output channel
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [HOURS_W-1:0]   result_hours,
    input  logic [MINUTES_W-1:0] result_minutes,
    input  logic [SECONDS_W-1:0] result_seconds,
    input  logic [FRAMES_W-1:0]  result_frames,
    input  logic                 matches_operand,
    input  logic                 refused,
    // Status for the testbench top
    output int                   fail_count,
    output int                   outstanding
);

    localparam logic [2:0] FRAME_MODE_ADDR = {REG_FRAME_MODE, 2'b00};

    // One predicted result item.
    typedef struct packed {
        tc_t  tc;
        logic matched;
        logic refd;
    } step_result_t;

    tc_t               timecode;
    logic [MODE_W-1:0] frame_mode;
    step_result_t      expected_steps[$];
    step_result_t      oldest;

    // Move a timecode one frame forward, wrapping after 23:59:59:last.
    function automatic tc_t tick_forward(input tc_t t, input int rate);
        tc_t n;
        n = t;
        if (n.frames + 1 < rate) begin
            n.frames = FRAMES_W'(n.frames + 1);
        end
        else begin
            n.frames = '0;
            if (n.seconds + 1 < 60) begin
                n.seconds = SECONDS_W'(n.seconds + 1);
            end
            else begin
                n.seconds = '0;
                if (n.minutes + 1 < 60) begin
                    n.minutes = MINUTES_W'(n.minutes + 1);
                end
                else begin
                    n.minutes = '0;
                    n.hours = (n.hours + 1 >= 24) ? '0 : HOURS_W'(n.hours + 1);
                end
            end
        end
        return n;
    endfunction

    // Move a timecode one frame back, wrapping below 00:00:00:00.
    function automatic tc_t tick_back(input tc_t t, input int rate);
        tc_t n;
        n = t;
        if (n.frames > 0) begin
            n.frames = FRAMES_W'(n.frames - 1);
        end
        else begin
            n.frames = FRAMES_W'(rate - 1);
            if (n.seconds > 0) begin
                n.seconds = SECONDS_W'(n.seconds - 1);
            end
            else begin
                n.seconds = MAX_SECONDS;
                if (n.minutes > 0) begin
                    n.minutes = MINUTES_W'(n.minutes - 1);
                end
                else begin
                    n.minutes = MAX_MINUTES;
                    n.hours = (n.hours > 0) ? HOURS_W'(n.hours - 1) : MAX_HOURS;
                end
            end
        end
        return n;
    endfunction

    // Apply one item to the stored timecode and return the result it should give.
    function automatic step_result_t advance_timecode(
        input logic [OP_W-1:0] op,
        input int              h,
        input int              m,
        input int              s,
        input int              f
    );
        logic [MODE_W-1:0] mode_eff;
        int                rate;
        int                oh;
        int                om;
        int                os;
        int                of;
        int                sum;
        int                carry;
        int                need;
        tc_t               t;
        step_result_t      r;

        // Unknown modes count as 30 fps nondrop.
        mode_eff = (frame_mode > MODE_PALM) ? MODE_30 : frame_mode;
        rate = (mode_eff == MODE_25) ? RATE_25 : (mode_eff == MODE_24) ? RATE_24 : RATE_30;
        oh = (h > MAX_HOURS) ? MAX_HOURS : h;
        om = (m > MAX_MINUTES) ? MAX_MINUTES : m;
        os = (s > MAX_SECONDS) ? MAX_SECONDS : s;
        of = (f > rate - 1) ? rate - 1 : f;

        // A frame count left over from a faster mode is pulled into range first.
        t = timecode;
        if (t.frames > rate - 1) begin
            t.frames = FRAMES_W'(rate - 1);
        end
        r.refd = 1'b0;

        case (op)
            OP_INC: begin
                t = tick_forward(t, rate);
                // Skip the dropped frames at the start of a minute.
                if (t.frames == 0 && t.seconds == 0) begin
                    if (mode_eff == MODE_NTSC && t.minutes % 10 != 0) begin
                        t.frames = NTSC_SKIP;
                    end
                    else if (mode_eff == MODE_PALM && t.minutes % 2 == 0 &&
                             t.minutes % 20 != 0) begin
                        t.frames = PALM_SKIP;
                    end
                end
            end
            OP_DEC: begin
                t = tick_back(t, rate);
                // Landing just below the first kept frame jumps to the previous minute.
                if (t.seconds == 0) begin
                    if (mode_eff == MODE_NTSC && t.frames == 1 && t.minutes % 10 != 0) begin
                        t.frames = '0;
                        t = tick_back(t, rate);
                    end
                    else if (mode_eff == MODE_PALM && t.frames == 3 &&
                             t.minutes % 2 == 0 && t.minutes % 20 != 0) begin
                        t.frames = '0;
                        t = tick_back(t, rate);
                    end
                end
            end
            OP_ADD, OP_SUB: begin
                if (mode_eff == MODE_NTSC || mode_eff == MODE_PALM) begin
                    r.refd = 1'b1;
                end
                else if (op == OP_ADD) begin
                    sum = t.frames + of;
                    carry = (sum >= rate) ? 1 : 0;
                    t.frames = FRAMES_W'(carry ? sum - rate : sum);
                    sum = t.seconds + os + carry;
                    carry = (sum >= 60) ? 1 : 0;
                    t.seconds = SECONDS_W'(carry ? sum - 60 : sum);
                    sum = t.minutes + om + carry;
                    carry = (sum >= 60) ? 1 : 0;
                    t.minutes = MINUTES_W'(carry ? sum - 60 : sum);
                    sum = t.hours + oh + carry;
                    t.hours = HOURS_W'((sum >= 24) ? sum - 24 : sum);
                end
                else begin
                    carry = (t.frames < of) ? 1 : 0;
                    t.frames = FRAMES_W'(carry ? t.frames + rate - of : t.frames - of);
                    need = os + carry;
                    carry = (t.seconds < need) ? 1 : 0;
                    t.seconds = SECONDS_W'(carry ? t.seconds + 60 - need : t.seconds - need);
                    need = om + carry;
                    carry = (t.minutes < need) ? 1 : 0;
                    t.minutes = MINUTES_W'(carry ? t.minutes + 60 - need : t.minutes - need);
                    need = oh + carry;
                    t.hours = HOURS_W'((t.hours < need) ? t.hours + 24 - need
                                                        : t.hours - need);
                end
            end
            OP_LOAD: begin
                t.hours   = HOURS_W'(oh);
                t.minutes = MINUTES_W'(om);
                t.seconds = SECONDS_W'(os);
                t.frames  = FRAMES_W'(of);
            end
            default: ;
        endcase

        r.matched = (t.hours == oh && t.minutes == om && t.seconds == os && t.frames == of);
        r.tc = t;
        timecode = t;
        return r;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Track the mode register, check each result item and predict each new item.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            timecode = '0;
            frame_mode = MODE_30;
            expected_steps.delete();
            outstanding = 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr == FRAME_MODE_ADDR) begin
                frame_mode = pwdata[MODE_W-1:0];
            end
            if (out_valid && !out_stall) begin
                if (expected_steps.size() == 0) begin
                    $error("result item arrived with no expected result waiting");
                    fail_count++;
                end
                else begin
                    oldest = expected_steps.pop_front();
                    compare_field("result_hours", oldest.tc.hours, result_hours);
                    compare_field("result_minutes", oldest.tc.minutes, result_minutes);
                    compare_field("result_seconds", oldest.tc.seconds, result_seconds);
                    compare_field("result_frames", oldest.tc.frames, result_frames);
                    compare_field("matches_operand", oldest.matched, matches_operand);
                    compare_field("refused", oldest.refd, refused);
                end
            end
            if (in_valid && !in_stall) begin
                expected_steps.push_back(advance_timecode(operation, operand_hours,
                    operand_minutes, operand_seconds, operand_frames));
            end
            outstanding = expected_steps.size();
        end
    end

endmodule

>>> bench/tb_smpte_timecode_counter_unit.sv
// Testbench top for the timecode counter: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_smpte_timecode_counter_unit;
    import stc_pkg::*;

    localparam logic [2:0] FRAME_MODE_ADDR = {REG_FRAME_MODE, 2'b00};
    localparam int SEGMENT_ITEMS = 66;
    localparam int SEGMENTS      = 12;
    localparam int HOLD_CYCLES   = 60;
    localparam int CYCLE_LIMIT   = 300000;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      operation = OP_INC;
    logic [HOURS_W-1:0]   operand_hours = '0;
    logic [MINUTES_W-1:0] operand_minutes = '0;
    logic [SECONDS_W-1:0] operand_seconds = '0;
    logic [FRAMES_W-1:0]  operand_frames = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [HOURS_W-1:0]   result_hours;
    logic [MINUTES_W-1:0] result_minutes;
    logic [SECONDS_W-1:0] result_seconds;
    logic [FRAMES_W-1:0]  result_frames;
    logic                 matches_operand;
    logic                 refused;

    int fail_count;
    int outstanding;
    int send_idle_pct = 38;
    int recv_idle_pct = 75;
    int cycle_count = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;

    smpte_timecode_counter_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .operand_hours(operand_hours), .operand_minutes(operand_minutes),
        .operand_seconds(operand_seconds), .operand_frames(operand_frames),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_hours(result_hours), .result_minutes(result_minutes),
        .result_seconds(result_seconds), .result_frames(result_frames),
        .matches_operand(matches_operand), .refused(refused)
    );

    stc_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .operand_hours(operand_hours), .operand_minutes(operand_minutes),
        .operand_seconds(operand_seconds), .operand_frames(operand_frames),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_hours(result_hours), .result_minutes(result_minutes),
        .result_seconds(result_seconds), .result_frames(result_frames),
        .matches_operand(matches_operand), .refused(refused),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    // 2 ns clock.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("smpte_timecode_counter_unit test failed");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off each time the token moves.
    always @(negedge clk)
    begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one item after a random gap and return at the falling edge after it is taken.
    task automatic offer_item(
        input logic [OP_W-1:0] op,
        input int              h,
        input int              m,
        input int              s,
        input int              f
    );
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid        = 1'b1;
        operation       = op;
        operand_hours   = HOURS_W'(h);
        operand_minutes = MINUTES_W'(m);
        operand_seconds = SECONDS_W'(s);
        operand_frames  = FRAMES_W'(f);
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_results();
        in_valid = 1'b0;
        while (outstanding != 0) begin
            @(negedge clk);
        end
    endtask

    // APB write of the frame mode: setup cycle, then access cycle.
    task automatic write_frame_mode(input logic [MODE_W-1:0] mode);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = FRAME_MODE_ADDR;
        pwdata  = 32'(mode);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Mostly in-range values, sometimes anything the field can hold.
    function automatic int pick_value(input int in_range_max, input int field_max);
        return ($urandom_range(9) == 0) ? $urandom_range(field_max) : $urandom_range(in_range_max);
    endfunction

    initial
    begin
        int                seg;
        int                sent;
        int                pick;
        int                steps;
        int                hrs;
        int                mins;
        bit                forward;
        logic [MODE_W-1:0] next_mode;
        logic [OP_W-1:0]   rand_op;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: 30 fps wraps, clamping, carry and borrow, unknown operation.
        write_frame_mode(MODE_30);
        offer_item(OP_INC, 0, 0, 0, 0);
        offer_item(OP_DEC, 0, 0, 0, 0);
        offer_item(OP_DEC, 0, 0, 0, 0);
        offer_item(OP_INC, 23, 59, 59, 29);
        offer_item(OP_LOAD, 23, 59, 59, 29);
        offer_item(OP_LOAD, 31, 63, 63, 31);
        offer_item(OP_ADD, 23, 59, 59, 29);
        offer_item(OP_SUB, 23, 59, 59, 29);
        offer_item(OP_SUB, 31, 63, 63, 31);
        offer_item(3'd7, 5, 5, 5, 5);

        // Directed: NTSC drop across a dropped minute and a tenth minute.
        drain_results();
        write_frame_mode(MODE_NTSC);
        offer_item(OP_LOAD, 0, 0, 59, 29);
        offer_item(OP_INC, 0, 0, 0, 0);
        offer_item(OP_DEC, 0, 0, 59, 29);
        offer_item(OP_LOAD, 0, 9, 59, 29);
        offer_item(OP_INC, 0, 10, 0, 0);
        offer_item(OP_ADD, 1, 1, 1, 1);

        // Directed: PAL-M drop, refusal and a load at 00:00:00:29.
        drain_results();
        write_frame_mode(MODE_PALM);
        offer_item(OP_LOAD, 0, 1, 59, 29);
        offer_item(OP_INC, 0, 0, 0, 0);
        offer_item(OP_DEC, 0, 0, 0, 0);
        offer_item(OP_LOAD, 0, 19, 59, 29);
        offer_item(OP_SUB, 0, 0, 0, 1);
        offer_item(OP_LOAD, 0, 0, 0, 29);

        // Directed: stored frames beyond the new rate, then an unknown mode.
        drain_results();
        write_frame_mode(MODE_24);
        offer_item(OP_INC, 0, 0, 0, 0);
        drain_results();
        write_frame_mode(3'd7);
        offer_item(OP_DEC, 0, 0, 0, 0);

        // Random segments, each under its own frame mode.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            drain_results();
            case (seg)
                8:       next_mode = MODE_NTSC;
                9:       next_mode = MODE_PALM;
                10:      next_mode = MODE_25;
                11:      next_mode = MODE_W'($urandom_range(7));
                default: next_mode = MODE_W'(seg % 8);
            endcase
            write_frame_mode(next_mode);
            if (seg == SEGMENTS / 3) begin
                send_idle_pct = 75;
                recv_idle_pct = 38;
            end
            if (seg == 2 * SEGMENTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Long receiver hold-off while items keep coming.
            if (seg == 2 * SEGMENTS / 3 + 1) begin
                hold_token = hold_token + 1;
            end

            sent = 0;
            while (sent < SEGMENT_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 20) begin
                    // Load near a second boundary, then step toward or across it.
                    forward = ($urandom_range(1) == 1);
                    case ($urandom_range(2))
                        0:       hrs = 0;
                        1:       hrs = 23;
                        default: hrs = $urandom_range(23);
                    endcase
                    case ($urandom_range(3))
                        0:       mins = 59;
                        1:       mins = 0;
                        default: mins = $urandom_range(59);
                    endcase
                    offer_item(OP_LOAD, hrs, mins, forward ? 59 : 0,
                               forward ? $urandom_range(23, 29) : $urandom_range(5));
                    steps = $urandom_range(2, 6);
                    repeat (steps) begin
                        offer_item(forward ? OP_INC : OP_DEC, $urandom_range(31),
                                   $urandom_range(63), $urandom_range(63), $urandom_range(31));
                    end
                    sent += steps + 1;
                end
                else begin
                    pick = $urandom_range(99);
                    if (pick < 28)      rand_op = OP_INC;
                    else if (pick < 50) rand_op = OP_DEC;
                    else if (pick < 64) rand_op = OP_ADD;
                    else if (pick < 78) rand_op = OP_SUB;
                    else if (pick < 92) rand_op = OP_LOAD;
                    else                rand_op = OP_W'($urandom_range(5, 7));
                    offer_item(rand_op, pick_value(23, 31), pick_value(59, 63),
                               pick_value(59, 63), pick_value(29, 31));
                    sent++;
                end
            end
        end

        // Let the last results come back and idle before the verdict.
        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("smpte_timecode_counter_unit test passed");
        end
        else begin
            $display("smpte_timecode_counter_unit test failed");
        end
        $finish;
    end

endmodule
